@@ rtl/ch3d_pkg.sv @@
// shared types, codes and constant tables for the joint colour histogram
// used by ch3d_ctrl, ch3d_datapath and color_histogram_3d_core; no dependencies
package ch3d_pkg;

  localparam int TOTAL_BINS   = 4096;
  localparam int ADDR_BITS    = 12;
  localparam int COUNT_BITS   = 20;
  localparam int BINS_BITS    = 5;
  localparam int CHAN_BITS    = 8;
  localparam int MAX_BINS     = 16;
  localparam int QIDX_BITS    = 4;
  localparam int RECIP_BITS   = 13;
  localparam int RECIP_SHIFT  = 16;
  localparam int PROD_BITS    = CHAN_BITS + RECIP_BITS;

  localparam logic [BINS_BITS-1:0] BINS_RESET = 5'd8;

  // configuration register indexes
  localparam logic [1:0] REG_BINS_FIRST  = 2'd0;
  localparam logic [1:0] REG_BINS_SECOND = 2'd1;
  localparam logic [1:0] REG_BINS_THIRD  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_READ     = 2'd1,
    FUNC_READ_CLR = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  // ceil(2^16 / ceil(256 / b)) for b = 1..16, indexed by b - 1;
  // (v * entry) >> 16 equals v / step exactly for any 8-bit v
  localparam logic [RECIP_BITS-1:0] RECIP [MAX_BINS] = '{
    13'd256,  13'd512,  13'd763,  13'd1024,
    13'd1261, 13'd1525, 13'd1772, 13'd2048,
    13'd2260, 13'd2521, 13'd2731, 13'd2979,
    13'd3277, 13'd3450, 13'd3641, 13'd4096
  };

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic quant;
    logic addr;
    logic mem_rd;
    logic mem_upd;
    logic out_load;
    logic clr_wr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic new_pixel;
    logic new_read;
    logic is_read;
    logic clr_last;
    logic out_full;
  } sts_t;

  // clamp a bins register to 1..16
  function automatic logic [BINS_BITS-1:0] eff_bins(input logic [BINS_BITS-1:0] r);
    logic [BINS_BITS-1:0] b;
    b = r;
    if (r == '0) begin
      b = BINS_BITS'(1);
    end else if (r > BINS_BITS'(MAX_BINS)) begin
      b = BINS_BITS'(MAX_BINS);
    end
    return b;
  endfunction

endpackage

@@ rtl/ch3d_ctrl.sv @@
// sequencing state machine for the joint colour histogram
// depends on ch3d_pkg for the command and status structs
module ch3d_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ch3d_pkg::sts_t sts,
  output ch3d_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUANT,
    ST_ADDR,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.new_pixel) begin
            state_nxt = ST_QUANT;
          end else if (sts.new_read) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_QUANT: begin
        cmd.quant = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // a read waits here until the output slot is free
        if (!(sts.is_read && sts.out_full)) begin
          cmd.mem_upd  = 1'b1;
          cmd.out_load = sts.is_read;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/ch3d_datapath.sv @@
// quantiser, address arithmetic, bin store and output register
// depends on ch3d_pkg for widths, tables and the command and status structs
module ch3d_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ch3d_pkg::cmd_t                    cmd,
  output ch3d_pkg::sts_t                    sts,
  input  logic [ch3d_pkg::BINS_BITS-1:0]    bins_first,
  input  logic [ch3d_pkg::BINS_BITS-1:0]    bins_second,
  input  logic [ch3d_pkg::BINS_BITS-1:0]    bins_third,
  input  logic [1:0]                        in_func,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]    in_chan_first,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]    in_chan_second,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]    in_chan_third,
  input  logic [ch3d_pkg::ADDR_BITS-1:0]    in_bin_select,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ch3d_pkg::COUNT_BITS-1:0]   out_bin_count,
  output logic                              out_count_saturated
);

  localparam int BB = ch3d_pkg::BINS_BITS;
  localparam int QB = ch3d_pkg::QIDX_BITS;
  localparam int AB = ch3d_pkg::ADDR_BITS;
  localparam int CB = ch3d_pkg::COUNT_BITS;
  localparam int PB = ch3d_pkg::PROD_BITS;
  localparam int P12_BITS = 2 * BB;

  ch3d_pkg::func_t            func_r;
  logic [ch3d_pkg::CHAN_BITS-1:0] v0_r, v1_r, v2_r;
  logic [BB-1:0]              b0_r, b1_r, b2_r;
  logic [QB-1:0]              i0_r, i1_r, i2_r;
  logic [P12_BITS-1:0]        p12_r;
  logic [AB-1:0]              addr_r;
  logic [AB-1:0]              clr_cnt_r;
  logic [CB-1:0]              rd_r;
  logic [CB-1:0]              mem [ch3d_pkg::TOTAL_BINS];
  logic                       out_valid_r;
  logic [CB-1:0]              out_count_r;
  logic                       out_sat_r;

  ch3d_pkg::func_t            in_func_e;
  logic [BB-1:0]              e0, e1, e2;
  logic [PB-1:0]              q0_prod, q1_prod, q2_prod;
  logic [AB:0]                addr_sum;
  logic                       rd_sat;
  logic                       we;
  logic [AB-1:0]              wa;
  logic [CB-1:0]              wd;

  assign in_func_e = ch3d_pkg::func_t'(in_func);
  assign e0 = ch3d_pkg::eff_bins(bins_first);
  assign e1 = ch3d_pkg::eff_bins(bins_second);
  assign e2 = ch3d_pkg::eff_bins(bins_third);

  // status towards the controller
  assign sts.new_pixel = (in_func_e == ch3d_pkg::FUNC_ADD);
  assign sts.new_read  = in_func_e inside {ch3d_pkg::FUNC_READ,
                                           ch3d_pkg::FUNC_READ_CLR};
  assign sts.is_read   = func_r inside {ch3d_pkg::FUNC_READ,
                                        ch3d_pkg::FUNC_READ_CLR};
  assign sts.clr_last  = &clr_cnt_r;
  assign sts.out_full  = out_valid_r && !out_ready;

  // reciprocal multiply per channel: value / step
  assign q0_prod = PB'(v0_r) * PB'(ch3d_pkg::RECIP[QB'(b0_r - BB'(1))]);
  assign q1_prod = PB'(v1_r) * PB'(ch3d_pkg::RECIP[QB'(b1_r - BB'(1))]);
  assign q2_prod = PB'(v2_r) * PB'(ch3d_pkg::RECIP[QB'(b2_r - BB'(1))]);

  // i0*b1*b2 + i1*b2 + i2, always below b0*b1*b2
  assign addr_sum = (AB+1)'(i0_r) * (AB+1)'(p12_r)
                  + (AB+1)'(i1_r) * (AB+1)'(b2_r)
                  + (AB+1)'(i2_r);

  // item capture and arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func_e;
      v0_r   <= in_chan_first;
      v1_r   <= in_chan_second;
      v2_r   <= in_chan_third;
      b0_r   <= e0;
      b1_r   <= e1;
      b2_r   <= e2;
      addr_r <= in_bin_select;
    end else if (cmd.addr) begin
      addr_r <= addr_sum[AB-1:0];
    end
    if (cmd.quant) begin
      i0_r  <= q0_prod[ch3d_pkg::RECIP_SHIFT +: QB];
      i1_r  <= q1_prod[ch3d_pkg::RECIP_SHIFT +: QB];
      i2_r  <= q2_prod[ch3d_pkg::RECIP_SHIFT +: QB];
      p12_r <= P12_BITS'(b1_r) * P12_BITS'(b2_r);
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AB'(1);
    end
  end

  // write port: clear sweep, saturating increment or read-and-clear
  assign rd_sat = &rd_r;
  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wd = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
      wa = clr_cnt_r;
    end else if (cmd.mem_upd) begin
      case (func_r)
        ch3d_pkg::FUNC_ADD: begin
          we = !rd_sat;
          wd = rd_r + CB'(1);
        end
        ch3d_pkg::FUNC_READ_CLR: begin
          we = 1'b1;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // bin store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[addr_r];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= rd_r;
      out_sat_r   <= rd_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bin_count       = out_count_r;
  assign out_count_saturated = out_sat_r;

endmodule

@@ rtl/color_histogram_3d_core.sv @@
// Joint three-channel colour histogram with 4096 saturating 20-bit bins.
// A pixel word quantises each channel by ceil(256/bins) and increments bin
// i0*b1*b2 + i1*b2 + i2; a read word returns one bin, read-and-clear also
// zeroes it. Each word goes through a read-modify-write of the bin store,
// so a pixel word passes through accept, quantise, address, store read
// and store write, a read word through accept, store read and store write
// plus any wait for the output register to drain, and an unused function
// code only accept. After reset the store is swept to zero with in_ready
// low; configuration writes are taken at any time and need no wait.
// depends on ch3d_pkg, ch3d_ctrl and ch3d_datapath
module color_histogram_3d_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [ch3d_pkg::BINS_BITS-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]    in_chan_first,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]    in_chan_second,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]    in_chan_third,
  input  logic [ch3d_pkg::ADDR_BITS-1:0]    in_bin_select,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ch3d_pkg::COUNT_BITS-1:0]   out_bin_count,
  output logic                              out_count_saturated
);

  logic [ch3d_pkg::BINS_BITS-1:0] bins_first_r, bins_second_r, bins_third_r;
  ch3d_pkg::cmd_t cmd;
  ch3d_pkg::sts_t sts;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_first_r  <= ch3d_pkg::BINS_RESET;
      bins_second_r <= ch3d_pkg::BINS_RESET;
      bins_third_r  <= ch3d_pkg::BINS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ch3d_pkg::REG_BINS_FIRST:  bins_first_r  <= cfg_data;
        ch3d_pkg::REG_BINS_SECOND: bins_second_r <= cfg_data;
        ch3d_pkg::REG_BINS_THIRD:  bins_third_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // controller
  ch3d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  ch3d_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .bins_first          (bins_first_r),
    .bins_second         (bins_second_r),
    .bins_third          (bins_third_r),
    .in_func             (in_func),
    .in_chan_first       (in_chan_first),
    .in_chan_second      (in_chan_second),
    .in_chan_third       (in_chan_third),
    .in_bin_select       (in_bin_select),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bin_count       (out_bin_count),
    .out_count_saturated (out_count_saturated)
  );

  // no word is taken while the clearing sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_ready)
    else $error("input accepted during clearing sweep");

  // a result is only loaded into a free output slot
  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output word overwritten");

  // pixel updates never produce a result
  a_pixel_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_upd && !sts.is_read) |-> !cmd.out_load)
    else $error("result produced for a pixel word");

  // capture only on an accepted input word
  a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (in_valid && in_ready))
    else $error("capture without handshake");

endmodule

@@ tb/sv/ch3d_bin_checker.sv @@
// bin store predictor and result checker for the joint colour histogram core
// watches the configuration, input and result channels; depends on ch3d_pkg
`timescale 1ns / 100ps
module ch3d_bin_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [ch3d_pkg::BINS_BITS-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]  in_chan_first,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]  in_chan_second,
  input  logic [ch3d_pkg::CHAN_BITS-1:0]  in_chan_third,
  input  logic [ch3d_pkg::ADDR_BITS-1:0]  in_bin_select,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [ch3d_pkg::COUNT_BITS-1:0] out_bin_count,
  input  logic                            out_count_saturated,
  output int                              mismatch_count,
  output int                              owed_reads
);
  import ch3d_pkg::*;

  localparam int unsigned LEVELS = 256;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  saturated;
  } bin_reply_t;

  logic [COUNT_BITS-1:0] tally [TOTAL_BINS];
  logic [BINS_BITS-1:0]  bins_first_q;
  logic [BINS_BITS-1:0]  bins_second_q;
  logic [BINS_BITS-1:0]  bins_third_q;
  bin_reply_t            replies_owed [$];
  int                    fault_tally = 0;

  initial begin
    mismatch_count = 0;
    owed_reads     = 0;
  end

  // register value as the block uses it: zero acts as one, excess as the maximum
  function automatic int unsigned live_bins(input logic [BINS_BITS-1:0] r);
    if (r == '0) return 1;
    if (r > BINS_BITS'(MAX_BINS)) return MAX_BINS;
    return r;
  endfunction

  // channel value to channel bin, step is ceil(256 / bins)
  function automatic int unsigned channel_slot(input logic [CHAN_BITS-1:0] v,
                                               input int unsigned nb);
    return v / ((LEVELS + nb - 1) / nb);
  endfunction

  task automatic report_mismatch(input string what);
    fault_tally++;
    $display("histogram check: mismatch at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin : track
    bin_reply_t  want;
    int unsigned b0;
    int unsigned b1;
    int unsigned b2;
    int unsigned spot;
    if (!rst_n) begin
      for (int a = 0; a < TOTAL_BINS; a++) tally[a] = '0;
      bins_first_q  = BINS_RESET;
      bins_second_q = BINS_RESET;
      bins_third_q  = BINS_RESET;
      replies_owed.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BINS_FIRST:  bins_first_q  = cfg_data;
          REG_BINS_SECOND: bins_second_q = cfg_data;
          REG_BINS_THIRD:  bins_third_q  = cfg_data;
          default: ;
        endcase
      end
      // accepted input word updates the store and may owe a reply
      if (in_valid && in_ready) begin
        case (func_t'(in_func))
          FUNC_ADD: begin
            b0 = live_bins(bins_first_q);
            b1 = live_bins(bins_second_q);
            b2 = live_bins(bins_third_q);
            spot = channel_slot(in_chan_first, b0) * b1 * b2
                 + channel_slot(in_chan_second, b1) * b2
                 + channel_slot(in_chan_third, b2);
            if (spot < TOTAL_BINS && tally[spot] != COUNT_TOP) begin
              tally[spot] = tally[spot] + 1'b1;
            end
          end
          FUNC_READ, FUNC_READ_CLR: begin
            want.count     = tally[in_bin_select];
            want.saturated = (tally[in_bin_select] == COUNT_TOP);
            replies_owed.push_back(want);
            if (func_t'(in_func) == FUNC_READ_CLR) tally[in_bin_select] = '0;
          end
          default: ;
        endcase
      end
      // accepted result word against the oldest owed reply
      if (out_valid && out_ready) begin
        if (replies_owed.size() == 0) begin
          report_mismatch($sformatf("unexpected result, count %0d", out_bin_count));
        end else begin
          want = replies_owed.pop_front();
          if (out_bin_count !== want.count) begin
            report_mismatch($sformatf("bin_count %0d, predicted %0d",
                                      out_bin_count, want.count));
          end
          if (out_count_saturated !== want.saturated) begin
            report_mismatch($sformatf("count_saturated %0b, predicted %0b",
                                      out_count_saturated, want.saturated));
          end
        end
      end
    end
    mismatch_count <= fault_tally;
    owed_reads     <= replies_owed.size();
  end

endmodule

@@ tb/sv/color_histogram_3d_core_tb.sv @@
// stimulus and verdict for color_histogram_3d_core: directed words, then
// random phases under several bin settings; depends on ch3d_pkg and ch3d_bin_checker
`timescale 1ns / 100ps
module color_histogram_3d_core_tb;
  import ch3d_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int CHOKE_CYCLES = 400;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = REG_BINS_FIRST;
  logic [BINS_BITS-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_func = FUNC_ADD;
  logic [CHAN_BITS-1:0]  in_chan_first = '0;
  logic [CHAN_BITS-1:0]  in_chan_second = '0;
  logic [CHAN_BITS-1:0]  in_chan_third = '0;
  logic [ADDR_BITS-1:0]  in_bin_select = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_BITS-1:0] out_bin_count;
  logic                  out_count_saturated;

  int   mismatch_count;
  int   owed_reads;
  int   cycle_count = 0;
  logic calm = 1'b0;
  logic choke_req = 1'b0;
  logic choke_done = 1'b0;

  color_histogram_3d_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_chan_first       (in_chan_first),
    .in_chan_second      (in_chan_second),
    .in_chan_third       (in_chan_third),
    .in_bin_select       (in_bin_select),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bin_count       (out_bin_count),
    .out_count_saturated (out_count_saturated)
  );

  ch3d_bin_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_chan_first       (in_chan_first),
    .in_chan_second      (in_chan_second),
    .in_chan_third       (in_chan_third),
    .in_bin_select       (in_bin_select),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bin_count       (out_bin_count),
    .out_count_saturated (out_count_saturated),
    .mismatch_count      (mismatch_count),
    .owed_reads          (owed_reads)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("color_histogram_3d_core_tb NOT OK");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (choke_req && !choke_done) begin
        out_ready <= 1'b0;
        for (int k = 0; k < CHOKE_CYCLES; k++) @(posedge clk);
        choke_done <= 1'b1;
      end
      out_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // offer one input word and hold it until taken
  task automatic send_word(input func_t f, input logic [CHAN_BITS-1:0] c0,
                           input logic [CHAN_BITS-1:0] c1,
                           input logic [CHAN_BITS-1:0] c2,
                           input logic [ADDR_BITS-1:0] sel);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_chan_first  <= c0;
    in_chan_second <= c1;
    in_chan_third  <= c2;
    in_bin_select  <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every owed reply is back and the last pixel has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_reads != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [BINS_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // new bin setting, only once the core is idle
  task automatic retune(input logic [BINS_BITS-1:0] b0, input logic [BINS_BITS-1:0] b1,
                        input logic [BINS_BITS-1:0] b2, input logic poke_spare);
    drain();
    write_reg(REG_BINS_FIRST, b0);
    write_reg(REG_BINS_SECOND, b1);
    write_reg(REG_BINS_THIRD, b2);
    if (poke_spare) write_reg(REG_SPARE, BINS_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // read address, mostly inside the configured bins
  function automatic logic [ADDR_BITS-1:0] aim_bin(input int span);
    if ($urandom_range(99) < 80) return ADDR_BITS'($urandom_range(span - 1));
    return ADDR_BITS'($urandom);
  endfunction

  // random mix of pixels, reads, clears and unused codes
  task automatic scatter_phase(input int n, input int span);
    logic [CHAN_BITS-1:0] shade [3][3];
    int roll;
    int pick;
    for (int p = 0; p < 3; p++) begin
      for (int c = 0; c < 3; c++) shade[p][c] = CHAN_BITS'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      pick = $urandom_range(2);
      if (roll < 55) begin
        if ($urandom_range(99) < 35) begin
          send_word(FUNC_ADD, shade[pick][0], shade[pick][1], shade[pick][2],
                    ADDR_BITS'($urandom));
        end else begin
          send_word(FUNC_ADD, CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                    CHAN_BITS'($urandom), ADDR_BITS'($urandom));
        end
      end else if (roll < 75) begin
        send_word(FUNC_READ, CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                  CHAN_BITS'($urandom), aim_bin(span));
      end else if (roll < 93) begin
        send_word(FUNC_READ_CLR, CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                  CHAN_BITS'($urandom), aim_bin(span));
      end else begin
        send_word(FUNC_NONE, CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                  CHAN_BITS'($urandom), ADDR_BITS'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting of 8 bins per channel: corners, patterns and bin edges
    send_word(FUNC_ADD, 8'd0, 8'd0, 8'd0, 12'hFFF);
    send_word(FUNC_ADD, 8'd0, 8'd0, 8'd0, 12'h000);
    send_word(FUNC_ADD, 8'd255, 8'd255, 8'd255, 12'hAAA);
    send_word(FUNC_ADD, 8'd31, 8'd32, 8'd63, 12'h555);
    send_word(FUNC_ADD, 8'hAA, 8'h55, 8'hAA, 12'h000);
    send_word(FUNC_ADD, 8'h55, 8'hAA, 8'h55, 12'hFFF);
    send_word(FUNC_NONE, 8'hFF, 8'hFF, 8'hFF, 12'h000);
    send_word(FUNC_READ, 8'h00, 8'h00, 8'h00, 12'd0);
    send_word(FUNC_READ, 8'hFF, 8'hFF, 8'hFF, 12'd511);
    send_word(FUNC_READ_CLR, 8'h00, 8'hFF, 8'h00, 12'd0);
    send_word(FUNC_READ, 8'h00, 8'h00, 8'h00, 12'd0);
    send_word(FUNC_READ, 8'h00, 8'h00, 8'h00, 12'd9);
    send_word(FUNC_READ, 8'h00, 8'h00, 8'h00, 12'd4095);
    send_word(FUNC_READ_CLR, 8'h00, 8'h00, 8'h00, 12'hAAA);
    send_word(FUNC_READ, 8'h00, 8'h00, 8'h00, 12'h555);

    // zero bins act as one, the store survives the change
    retune(5'd0, 5'd0, 5'd0, 1'b0);
    send_word(FUNC_ADD, 8'd200, 8'd100, 8'd50, 12'd0);
    send_word(FUNC_READ, 8'h00, 8'h00, 8'h00, 12'd511);
    send_word(FUNC_READ_CLR, 8'h00, 8'h00, 8'h00, 12'd0);

    // oversized bins act as sixteen, top corner lands on the last bin
    retune(5'd31, 5'd31, 5'd31, 1'b0);
    send_word(FUNC_ADD, 8'd255, 8'd255, 8'd255, 12'd0);
    send_word(FUNC_ADD, 8'd255, 8'd255, 8'd255, 12'd0);
    send_word(FUNC_READ_CLR, 8'h00, 8'h00, 8'h00, 12'd4095);
    send_word(FUNC_READ, 8'h00, 8'h00, 8'h00, 12'd4095);

    // random phases over a range of settings
    retune(5'd16, 5'd16, 5'd16, 1'b0);
    scatter_phase(220, 4096);
    retune(5'd1, 5'd1, 5'd1, 1'b0);
    scatter_phase(150, 16);
    retune(5'd3, 5'd7, 5'd5, 1'b0);
    choke_req <= 1'b1;
    scatter_phase(220, 105);
    retune(5'd31, 5'd17, 5'd20, 1'b0);
    scatter_phase(200, 4096);

    // no idling on either side, then a full clearing readout
    retune(5'd2, 5'd3, 5'd2, 1'b0);
    calm <= 1'b1;
    scatter_phase(200, 12);
    for (int a = 0; a < 12; a++) begin
      send_word(FUNC_READ_CLR, CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                CHAN_BITS'($urandom), ADDR_BITS'(a));
    end
    for (int a = 0; a < 12; a++) begin
      send_word(FUNC_READ, CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                CHAN_BITS'($urandom), ADDR_BITS'(a));
    end
    calm <= 1'b0;

    retune(5'd16, 5'd1, 5'd9, 1'b0);
    scatter_phase(200, 144);
    retune(5'd4, 5'd4, 5'd4, 1'b1);
    scatter_phase(200, 64);
    retune(BINS_BITS'($urandom), BINS_BITS'($urandom), BINS_BITS'($urandom), 1'b0);
    scatter_phase(150, 4096);

    drain();
    if (mismatch_count == 0) begin
      $display("color_histogram_3d_core_tb OK");
    end else begin
      $display("color_histogram_3d_core_tb NOT OK");
    end
    $finish;
  end

endmodule
